// ===== hw/rtl/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
// Holds the fixed prime, the Barrett reduction constant and the sequencer types.
// No dependencies.
`timescale 1ns / 1ps

package mexp_pkg;

  // Residue width; the prime lies in [2^(RES_W-1), 2^RES_W), as Barrett needs.
  localparam int RES_W  = 30;
  // Width of the raw base operand and of the exponent.
  localparam int BASE_W = 32;
  localparam int EXP_W  = 32;
  // Full product width of a BASE_W by RES_W multiply.
  localparam int PROD_W = BASE_W + RES_W;
  // Barrett quotient width and width of the partial remainder (below 3 * prime).
  localparam int Q_W    = RES_W + 1;
  localparam int R_W    = RES_W + 2;

  localparam logic [RES_W-1:0] MODULUS = RES_W'(998244353);

  // Barrett constant: floor(2^(2*RES_W) / MODULUS), which fits in Q_W bits.
  localparam logic [63:0] MU_FULL = (64'd1 << (2 * RES_W)) / 64'(MODULUS);
  localparam logic [Q_W-1:0] BARRETT_MU = MU_FULL[Q_W-1:0];

  // Multiples of the prime used by the final correction.
  localparam logic [R_W-1:0] MOD_X1 = {2'b00, MODULUS};
  localparam logic [R_W-1:0] MOD_X2 = {1'b0, MODULUS, 1'b0};

  // Fermat exponent used for the inverse.
  localparam logic [EXP_W-1:0] INV_EXP = EXP_W'(MODULUS) - EXP_W'(2);

  // Destination register of a multiplier result.
  typedef enum logic {
    DST_SQ,
    DST_ACC
  } dst_t;

  // Control that travels with each multiply down the pipeline.
  typedef struct packed {
    logic valid;
    dst_t dst;
  } mm_ctl_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_MULT,
    ST_WAIT,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/modular_exponentiation.sv =====
// Top level: modular exponentiation by right-to-left square-and-multiply.
// A small sequencer drives one shared pipelined modular multiplier.
// Depends on mexp_pkg and mexp_mulmod.
`timescale 1ns / 1ps
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------
//  in      | in_valid / in_ready  | kind, base_value, exponent
//  out     | out_valid / out_ready| residue
//
// One request at a time; in_ready is high only while the block is idle.
// The base is reduced on the multiplier first; then each exponent bit issues a
// square, plus a multiply by the square when the bit is set, and waits until
// both leave the four-stage shared multiplier. Work stops at the top set bit.
// Reset is synchronous; the result is held in the done state until out_ready.

module modular_exponentiation import mexp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              kind,
  input  logic [BASE_W-1:0] base_value,
  input  logic [EXP_W-1:0]  exponent,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [RES_W-1:0]  residue
);

  state_t              state, state_next;
  logic [EXP_W-1:0]    e;
  logic [RES_W-1:0]    sq;
  logic [RES_W-1:0]    acc;
  logic [1:0]          pend, pend_next;
  logic                accept;
  mm_ctl_t             issue;
  logic [BASE_W-1:0]   issue_a;
  logic [RES_W-1:0]    issue_b;
  mm_ctl_t             mm_ctl;
  logic [RES_W-1:0]    mm_value;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_DONE);
  assign residue   = acc;

  // Shared modular multiplier.
  mexp_mulmod u_mulmod (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (issue),
    .in_a      (issue_a),
    .in_b      (issue_b),
    .out_ctl   (mm_ctl),
    .out_value (mm_value)
  );

  // Count of multiplies in flight.
  assign pend_next = pend + {1'b0, issue.valid} - {1'b0, mm_ctl.valid};

  // Sequencer: next state and multiplier issue.
  always_comb begin
    state_next = state;
    issue      = '{valid: 1'b0, dst: DST_SQ};
    issue_a    = '0;
    issue_b    = '0;
    case (state)
      ST_IDLE: begin
        // Reduce the base by multiplying it by one.
        issue.valid = in_valid;
        issue_a     = base_value;
        issue_b     = RES_W'(1);
        if (in_valid) begin
          state_next = ST_WAIT;
        end
      end
      ST_SQUARE: begin
        // The square is not needed for the last exponent bit.
        issue.valid = |e[EXP_W-1:1];
        issue_a     = BASE_W'(sq);
        issue_b     = sq;
        state_next  = e[0] ? ST_MULT : ST_WAIT;
      end
      ST_MULT: begin
        issue.valid = 1'b1;
        issue.dst   = DST_ACC;
        issue_a     = BASE_W'(acc);
        issue_b     = sq;
        state_next  = ST_WAIT;
      end
      ST_WAIT: begin
        if (pend_next == 2'd0) begin
          state_next = (e == '0) ? ST_DONE : ST_SQUARE;
        end
      end
      ST_DONE: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 2'd0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  // Exponent, square and accumulator registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      e <= kind ? INV_EXP : exponent;
    end else if (state == ST_SQUARE) begin
      e <= e >> 1;
    end
    if (accept) begin
      acc <= RES_W'(1);
    end else if (mm_ctl.valid && (mm_ctl.dst == DST_ACC)) begin
      acc <= mm_value;
    end
    if (mm_ctl.valid && (mm_ctl.dst == DST_SQ)) begin
      sq <= mm_value;
    end
  end

`ifndef NO_ASSERTIONS
  // At most a square and a multiply are in flight.
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend != 2'd3)
    else $error("too many multiplies in flight");

  // Multiplier results only come back while the sequencer waits for them.
  a_result_in_wait: assert property (@(posedge clk) disable iff (rst)
    mm_ctl.valid |-> (state == ST_WAIT))
    else $error("multiplier result outside the wait state");

  // The delivered result is a residue and nothing is in flight.
  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((residue < MODULUS) && (pend == 2'd0)))
    else $error("result delivered with bad value or work in flight");
`endif

endmodule

// ===== hw/rtl/mexp_mulmod.sv =====
// Pipelined modular multiplier with Barrett reduction by the fixed prime.
// Four register stages: product, quotient estimate, quotient times prime, remainder.
// Depends on mexp_pkg.
`timescale 1ns / 1ps

module mexp_mulmod import mexp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  mm_ctl_t           in_ctl,
  input  logic [BASE_W-1:0] in_a,
  input  logic [RES_W-1:0]  in_b,
  output mm_ctl_t           out_ctl,
  output logic [RES_W-1:0]  out_value
);

  mm_ctl_t             ctl1, ctl2, ctl3, ctl4;
  logic [PROD_W-1:0]   prod;
  logic [Q_W-1:0]      q3;
  logic [R_W-1:0]      plo2, plo3;
  logic [R_W-1:0]      qm;
  logic [R_W-1:0]      rem;
  logic [2*Q_W-1:0]    q2;
  logic [Q_W+RES_W-1:0] qm_full;
  logic [R_W-1:0]      rem_fix;

  // Control pipeline; only the valid bits need reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
      ctl4 <= '0;
    end else begin
      ctl1 <= in_ctl;
      ctl2 <= ctl1;
      ctl3 <= ctl2;
      ctl4 <= ctl3;
    end
  end

  // Quotient estimate and quotient times prime. The operands never give a
  // product of 2^(2*RES_W) or more, so the top product bits are zero.
  always_comb begin
    q2      = (2*Q_W)'(prod[2*RES_W-1:RES_W-1]) * (2*Q_W)'(BARRETT_MU);
    qm_full = (Q_W+RES_W)'(q3) * (Q_W+RES_W)'(MODULUS);
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    prod <= PROD_W'(in_a) * PROD_W'(in_b);
    q3   <= q2[2*Q_W-1:RES_W+1];
    plo2 <= prod[R_W-1:0];
    qm   <= qm_full[R_W-1:0];
    plo3 <= plo2;
    rem  <= plo3 - qm;
  end

  // The remainder is below three times the prime; fold it once.
  always_comb begin
    if (rem >= MOD_X2) begin
      rem_fix = rem - MOD_X2;
    end else if (rem >= MOD_X1) begin
      rem_fix = rem - MOD_X1;
    end else begin
      rem_fix = rem;
    end
  end

  assign out_ctl   = ctl4;
  assign out_value = rem_fix[RES_W-1:0];

`ifndef NO_ASSERTIONS
  // A request that enters the pipeline comes out of its last stage.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_ctl.valid |-> ##4 out_ctl.valid)
    else $error("mulmod result missing four cycles after issue");

  // The destination tag follows its request through the stages.
  a_dst_follows: assert property (@(posedge clk) disable iff (rst)
    in_ctl.valid |-> ##4 (out_ctl.dst == $past(in_ctl.dst, 4)))
    else $error("mulmod destination tag corrupted");

  // The corrected remainder is a residue.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_ctl.valid |-> (out_value < MODULUS))
    else $error("mulmod result not reduced");
`endif

endmodule

// ===== tb/modular_exponentiation_tb.sv =====
// Testbench for modular_exponentiation: powers and inverses modulo the fixed prime.
// Checks every residue against a predictor of its own; needs mexp_pkg and the block RTL.
`timescale 1ns / 1ps

module modular_exponentiation_tb;
  import mexp_pkg::*;

  // Request kinds.
  localparam logic KIND_POWER   = 1'b0;
  localparam logic KIND_INVERSE = 1'b1;

  localparam int RANDOM_REQUESTS = 500;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 250;
  localparam int CYCLE_LIMIT     = 1000000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              kind = KIND_POWER;
  logic [BASE_W-1:0] base_value = '0;
  logic [EXP_W-1:0]  exponent = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [RES_W-1:0]  residue;

  // Residues still owed by the block, oldest first.
  logic [RES_W-1:0]  residue_q[$];
  logic [RES_W-1:0]  expected_residue;
  int                errors = 0;
  int                cycles = 0;
  // Random idling on both sides, and a request for one long output stall.
  bit                idle_on = 1'b1;
  bit                hold_req = 1'b0;

  modular_exponentiation i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .base_value (base_value),
    .exponent   (exponent),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .residue    (residue)
  );

  always #4 clk = ~clk;

  // Expected residue of one request, by right-to-left square-and-multiply.
  function automatic logic [RES_W-1:0] residue_pow(logic k, logic [BASE_W-1:0] b,
                                                   logic [EXP_W-1:0] e);
    logic [63:0]      m;
    logic [63:0]      acc;
    logic [63:0]      sq;
    logic [EXP_W-1:0] bits;
    m   = 64'(MODULUS);
    sq  = 64'(b) % m;
    acc = 64'd1;
    if (k == KIND_INVERSE) begin
      // Fermat's rule; zero has no inverse and maps to zero.
      if (sq == 64'd0) return '0;
      bits = EXP_W'(m - 64'd2);
    end else begin
      bits = e;
    end
    while (bits != '0) begin
      if (bits[0]) acc = (acc * sq) % m;
      sq   = (sq * sq) % m;
      bits = bits >> 1;
    end
    return RES_W'(acc);
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request and record its residue once the block takes it.
  task automatic send_request(input logic k, input logic [BASE_W-1:0] b,
                              input logic [EXP_W-1:0] e);
    int gap;
    gap = idle_on ? gap_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    kind       = k;
    base_value = b;
    exponent   = e;
    in_valid   = 1'b1;
    do @(posedge clk); while (!in_ready);
    residue_q.push_back(residue_pow(k, b, e));
  endtask

  // A zero exponent gives one for any base, zero included.
  task automatic test_zero_exponent();
    send_request(KIND_POWER, '0, '0);
    send_request(KIND_POWER, 32'd5, '0);
    send_request(KIND_POWER, BASE_W'(MODULUS), '0);
    send_request(KIND_POWER, '1, '0);
  endtask

  // Powers at the edges of the base and exponent ranges.
  task automatic test_operand_extremes();
    send_request(KIND_POWER, '0, 32'd1);
    send_request(KIND_POWER, '1, '1);
    send_request(KIND_POWER, 32'd1, '1);
    send_request(KIND_POWER, BASE_W'(MODULUS) - 32'd1, 32'd2);
    send_request(KIND_POWER, BASE_W'(MODULUS), 32'd5);
    send_request(KIND_POWER, BASE_W'(MODULUS) + 32'd1, 32'd123456);
    send_request(KIND_POWER, 32'd2, 32'd31);
    send_request(KIND_POWER, 32'h8000_0000, 32'h8000_0000);
    send_request(KIND_POWER, 32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  // Inverses, including bases that reduce to zero; the exponent field is ignored.
  task automatic test_inverse();
    send_request(KIND_INVERSE, '0, '1);
    send_request(KIND_INVERSE, BASE_W'(MODULUS), 32'd7);
    send_request(KIND_INVERSE, BASE_W'(MODULUS) * 32'd2, '0);
    send_request(KIND_INVERSE, 32'd1, '1);
    send_request(KIND_INVERSE, 32'd2, '0);
    send_request(KIND_INVERSE, BASE_W'(MODULUS) - 32'd1, 32'd3);
    send_request(KIND_INVERSE, '1, $urandom);
  endtask

  // The receiver stalls for a long stretch while requests keep coming.
  task automatic test_output_backpressure();
    hold_req = 1'b1;
    repeat (4) send_request(KIND_POWER, $urandom, $urandom);
    send_request(KIND_INVERSE, $urandom, $urandom);
  endtask

  // Random requests, mostly with short exponents; one stretch runs without idling.
  task automatic test_random_requests();
    logic              k;
    logic [BASE_W-1:0] b;
    logic [EXP_W-1:0]  e;
    int                sel;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      idle_on = !(i >= 200 && i < 260);
      k = ($urandom_range(0, 99) < 25) ? KIND_INVERSE : KIND_POWER;
      sel = $urandom_range(0, 9);
      case (sel)
        0: b = '0;
        1: b = BASE_W'(MODULUS) * BASE_W'($urandom_range(1, 4));
        2: b = $urandom_range(0, 1) ? BASE_W'(MODULUS) - 32'd1 : BASE_W'(MODULUS) + 32'd1;
        default: b = $urandom;
      endcase
      sel = $urandom_range(0, 9);
      case (sel)
        0: e = '0;
        1, 2, 3: e = $urandom;
        default: e = $urandom >> $urandom_range(1, 31);
      endcase
      send_request(k, b, e);
    end
    idle_on = 1'b1;
  endtask

  // Output side: random stalls, or one long hold when a test asks for it.
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        gap = idle_on ? gap_len() : 0;
        if (gap > 0) begin
          out_ready = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end else begin
          out_ready = 1'b1;
        end
      end
    end
  end

  // Compare each residue taken from the block with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (residue_q.size() == 0) begin
        $display("%0t: residue with none expected, expected none, actual %0d", $time, residue);
        errors++;
      end else begin
        expected_residue = residue_q.pop_front();
        if (residue !== expected_residue) begin
          $display("%0t: residue mismatch, expected %0d, actual %0d", $time,
                   expected_residue, residue);
          errors++;
        end
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d residues outstanding", $time, residue_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_zero_exponent();
    test_operand_extremes();
    test_inverse();
    test_output_backpressure();
    test_random_requests();
    @(negedge clk);
    in_valid = 1'b0;
    while (residue_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
